[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define FBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the check above.
`define FBE_ASSERT_IMPL(label, cond, prop, msg) \
    `FBE_ASSERT(label, (cond) |-> (prop), msg)

`endif

[hdl/fbecho_pkg.sv]
package fbecho_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 12;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] RST_DELAY_SAMPLES = 16'd9600;
    localparam logic [15:0] RST_DELAY_GAIN    = 16'd0;
    localparam logic        RST_MOD_ENABLE    = 1'b0;
    localparam logic [15:0] RST_LFO_FACTOR    = 16'd8192;
    localparam logic [15:0] RST_METER_WINDOW  = 16'd960;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_SAMPLES = 3'd0,
        CFG_DELAY_GAIN    = 3'd1,
        CFG_MOD_ENABLE    = 3'd2,
        CFG_LFO_FACTOR    = 3'd3,
        CFG_METER_WINDOW  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_IDX,
        S_LOOK,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic addr;
        logic mul1;
        logic mul2;
        logic sum;
        logic idx;
        logic look;
        logic div;
        logic fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic mod_en;
        logic win_close;
        logic out_free;
    } status_t;

    // Q16 base-2 logarithm, used only to build the level table at elaboration.
    function automatic longint unsigned lg_q16(input longint unsigned v);
        longint unsigned n;
        longint unsigned y;
        longint unsigned frac;
        n    = 0;
        frac = 0;
        if (v < 64'd65536)
        begin
            return 64'd0;
        end
        for (int s = 0; s < 48; s++)
        begin
            if ((v >> n) >= 64'd131072)
            begin
                n = n + 1;
            end
        end
        y = v >> n;
        for (int k = 15; k >= 0; k--)
        begin
            y = (y * y) >> 16;
            if (y >= 64'd131072)
            begin
                y    = y >> 1;
                frac = frac | (64'd1 << k);
            end
        end
        return (n << 16) | frac;
    endfunction

    localparam longint unsigned V_FULL = 64'd2621440;
    localparam longint unsigned LG_V40 = lg_q16(V_FULL);

endpackage

[hdl/fbecho_ram.sv]
module fbecho_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fbecho_ctrl.sv]
module fbecho_ctrl
    import fbecho_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: state_next = S_MUL1;
            S_MUL1: state_next = status.mod_en ? S_MUL2 : S_SUM;
            S_MUL2: state_next = S_SUM;
            S_SUM:  state_next = status.win_close ? S_IDX : S_OUT;
            S_IDX:  state_next = S_LOOK;
            S_LOOK: state_next = S_DIV;
            S_DIV:  state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_ADDR: cmd.addr = 1'b1;
            S_MUL1: cmd.mul1 = 1'b1;
            S_MUL2: cmd.mul2 = 1'b1;
            S_SUM:  cmd.sum  = 1'b1;
            S_IDX:  cmd.idx  = 1'b1;
            S_LOOK: cmd.look = 1'b1;
            S_DIV:  cmd.div  = 1'b1;
            S_FIN:  cmd.fin  = 1'b1;
            S_OUT:  cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[hdl/fbecho_datapath.sv]
`include "assert_macros.svh"

module fbecho_datapath
    import fbecho_pkg::*;
#(
    parameter int BUF_DEPTH         = 65536,
    parameter int LEVEL_TABLE_DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    // Wide enough for BUF_DEPTH shifted up to the top reduction step.
    localparam int MW        = ADDR_W + 7;
    // With at least 1024 entries a 16-bit distance is under 64 depths.
    localparam int MOD_STEPS = 7;
    localparam int LT_IDX_W  = $clog2(LEVEL_TABLE_DEPTH);
    localparam int LT_D1     = LEVEL_TABLE_DEPTH - 1;

    // Configuration registers
    logic [15:0]        delay_samples_reg, delay_gain_reg, meter_window_reg;
    logic signed [15:0] lfo_factor_reg;
    logic               mod_enable_reg;

    // Control state
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic               full_reg, full_next;
    logic [15:0]        peak_reg, peak_next;
    logic [15:0]        wcount_reg, wcount_next;
    logic [LEVEL_W-1:0] last_raw_reg, last_raw_next;
    logic [LEVEL_W-1:0] shown_reg, shown_next;
    logic               m_valid_reg, m_valid_next;

    // Per-word working registers
    logic signed [15:0]  mix_reg, mix_next;
    logic [ADDR_W-1:0]   dist_reg;
    logic                rd_hit_reg, rd_hit_next;
    logic signed [32:0]  prod_reg, prod_next;
    logic signed [48:0]  prod2_reg, prod2_next;
    logic signed [15:0]  o_reg, o_next;
    logic                upd_reg;
    logic [LT_IDX_W-1:0] idx_reg, idx_next;
    logic [LEVEL_W-1:0]  raw_reg;
    logic [LEVEL_W-1:0]  quo_reg, quo_next;
    logic [15:0]         out_sample_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_upd_reg;

    logic signed [15:0]  left_s, right_s;
    logic signed [16:0]  lr_sum;
    logic [ADDR_W:0]     rd_sum;
    logic [ADDR_W-1:0]   rd_addr;
    logic [15:0]         ram_rdata;
    logic signed [15:0]  d_val;
    logic signed [16:0]  gain_s;
    logic signed [33:0]  rnd_nm;
    logic signed [49:0]  rnd_m;
    logic signed [18:0]  echo;
    logic signed [19:0]  o_wide;
    logic signed [16:0]  o_ext;
    logic signed [16:0]  mag;
    logic [15:0]         wc_inc;
    logic [15:0]         win;
    logic                win_close;
    logic [28:0]         idx_prod;
    logic [13:0]         idx_raw;
    logic [15:0]         div_x;
    logic [31:0]         div_prod;
    logic [LEVEL_W-1:0]  level_rom [LEVEL_TABLE_DEPTH];

    function automatic logic [ADDR_W-1:0] dist_mod(input logic [15:0] dly);
        logic [MW-1:0] r;
        r = MW'(dly);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (r >= (MW'(BUF_DEPTH) << k))
            begin
                r = r - (MW'(BUF_DEPTH) << k);
            end
        end
        return r[ADDR_W-1:0];
    endfunction

    // Level table: log-scaled 12-bit level for each peak bin.
    for (genvar i = 0; i < LEVEL_TABLE_DEPTH; i++)
    begin : g_level
        localparam longint unsigned VI = 64'd65536 + (V_FULL * i) / LT_D1;
        localparam longint unsigned LV = (64'd4095 * lg_q16(VI) + LG_V40 / 2) / LG_V40;
        assign level_rom[i] = (LV > 64'd4095) ? 12'd4095 : LEVEL_W'(LV);
    end

    fbecho_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.sum),
        .waddr (wp_reg),
        .wdata (o_next),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= RST_DELAY_SAMPLES;
            delay_gain_reg    <= RST_DELAY_GAIN;
            mod_enable_reg    <= RST_MOD_ENABLE;
            lfo_factor_reg    <= RST_LFO_FACTOR;
            meter_window_reg  <= RST_METER_WINDOW;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DELAY_SAMPLES: delay_samples_reg <= cfg_data;
                CFG_DELAY_GAIN:    delay_gain_reg    <= cfg_data;
                CFG_MOD_ENABLE:    mod_enable_reg    <= cfg_data[0];
                CFG_LFO_FACTOR:    lfo_factor_reg    <= cfg_data;
                CFG_METER_WINDOW:  meter_window_reg  <= cfg_data;
                default:           delay_samples_reg <= delay_samples_reg;
            endcase
        end
    end

    // Input mix: floor of half the sum.
    assign left_s   = s_tdata[15:0];
    assign right_s  = s_tdata[31:16];
    assign lr_sum   = 17'(left_s) + 17'(right_s);
    assign mix_next = 16'(lr_sum >>> 1);

    // Read address behind the write pointer. Entries not yet written since
    // reset read as zero: written ones lie below the pointer until the first wrap, all after.
    always_comb
    begin
        rd_sum = (ADDR_W + 1)'(wp_reg) + (ADDR_W + 1)'(BUF_DEPTH) - (ADDR_W + 1)'(dist_reg);
        if (rd_sum >= (ADDR_W + 1)'(BUF_DEPTH))
        begin
            rd_sum = rd_sum - (ADDR_W + 1)'(BUF_DEPTH);
        end
        rd_addr     = rd_sum[ADDR_W-1:0];
        rd_hit_next = full_reg || (rd_addr < wp_reg);
    end

    assign d_val      = rd_hit_reg ? $signed(ram_rdata) : 16'sd0;
    assign gain_s     = {1'b0, delay_gain_reg};
    assign prod_next  = d_val * gain_s;
    assign prod2_next = prod_reg * lfo_factor_reg;

    always_comb
    begin
        rnd_nm = 34'(prod_reg) + 34'sd16384;
        rnd_m  = 50'(prod2_reg) + 50'sd268435456;
        echo   = mod_enable_reg ? 19'(rnd_m >>> 29) : 19'(rnd_nm >>> 15);
        o_wide = 20'(mix_reg) + 20'(echo);
        if (o_wide > 20'sd32767)
        begin
            o_next = 16'sd32767;
        end
        else if (o_wide < -20'sd32768)
        begin
            o_next = -16'sd32768;
        end
        else
        begin
            o_next = 16'(o_wide);
        end
        o_ext = 17'(o_next);
        mag   = o_ext[16] ? -o_ext : o_ext;
    end

    assign wc_inc    = wcount_reg + 16'd1;
    assign win       = (meter_window_reg == 16'd0) ? 16'd1 : meter_window_reg;
    assign win_close = (wc_inc >= win);

    always_comb
    begin
        idx_prod = 29'(peak_reg) * 29'(LT_D1) + 29'd16384;
        idx_raw  = idx_prod[28:15];
        if (idx_raw > 14'(LT_D1))
        begin
            idx_next = LT_IDX_W'(LT_D1);
        end
        else
        begin
            idx_next = idx_raw[LT_IDX_W-1:0];
        end
    end

    // Divide by ten through the reciprocal; exact for the values that occur.
    assign div_x    = 16'(raw_reg) + 16'(last_raw_reg) * 16'd9 + 16'd5;
    assign div_prod = 32'(div_x) * 32'd52429;
    assign quo_next = div_prod[30:19];

    always_comb
    begin
        wp_next       = wp_reg;
        full_next     = full_reg;
        peak_next     = peak_reg;
        wcount_next   = wcount_reg;
        last_raw_next = last_raw_reg;
        shown_next    = shown_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        if (cmd.sum)
        begin
            if (wp_reg == ADDR_W'(BUF_DEPTH - 1))
            begin
                wp_next   = '0;
                full_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
            if (mag[15:0] > peak_reg)
            begin
                peak_next = mag[15:0];
            end
            wcount_next = win_close ? 16'd0 : wc_inc;
        end
        if (cmd.idx)
        begin
            peak_next = '0;
        end
        if (cmd.fin)
        begin
            shown_next    = (raw_reg < last_raw_reg) ? quo_reg : raw_reg;
            last_raw_next = raw_reg;
        end
        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            peak_reg     <= '0;
            wcount_reg   <= '0;
            last_raw_reg <= '0;
            shown_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            full_reg     <= full_next;
            peak_reg     <= peak_next;
            wcount_reg   <= wcount_next;
            last_raw_reg <= last_raw_next;
            shown_reg    <= shown_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mix_reg  <= mix_next;
            dist_reg <= dist_mod(delay_samples_reg);
        end
        if (cmd.addr)
        begin
            rd_hit_reg <= rd_hit_next;
        end
        if (cmd.mul1)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul2)
        begin
            prod2_reg <= prod2_next;
        end
        if (cmd.sum)
        begin
            o_reg   <= o_next;
            upd_reg <= win_close;
        end
        if (cmd.idx)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.look)
        begin
            raw_reg <= level_rom[idx_reg];
        end
        if (cmd.div)
        begin
            quo_reg <= quo_next;
        end
        if (cmd.load_out)
        begin
            out_sample_reg <= o_reg;
            out_level_reg  <= shown_reg;
            out_upd_reg    <= upd_reg;
        end
    end

    assign status.mod_en    = mod_enable_reg;
    assign status.win_close = win_close;
    assign status.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_level_reg, out_sample_reg};
    assign m_tuser  = out_upd_reg;

    // The write pointer moves only when a sample is stored, by one place.
    `FBE_ASSERT(a_wp_step, (!cmd.sum |=> $stable(wp_reg)) and (cmd.sum |=> (wp_reg == '0 || wp_reg == $past(wp_reg) + 1'b1)), "write pointer moved out of step")
    // A new result is never loaded over one that has not been taken.
    `FBE_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !m_valid_reg || m_tready, "undelivered result overwritten")
    // A result that closes a window leaves the meter window state cleared.
    `FBE_ASSERT_IMPL(a_window_cleared, cmd.load_out && upd_reg, wcount_reg == '0 && peak_reg == '0, "window state not cleared on meter update")

endmodule

[hdl/feedback_echo_with_peak_meter_core.sv]
// Channel  Direction  Handshake          Contents
// s_*      in         s_tvalid/s_tready  tdata: left_sample, right_sample
// m_*      out        m_tvalid/m_tready  tdata: out_sample, meter_level; tuser: meter_updated
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// One word is processed at a time by the sequencer: accept, address, first multiply, a second
// multiply when modulation is on, sum and store, then index, lookup, divide and finish when
// the word closes a meter window, and output load, from the registered delay-store read.
// The result waits in an output register, so the next word is taken while it is unread;
// a stalled output holds the sequencer only when a second result is ready.
// No clearing pass after reset: a fill mark makes unwritten store entries read as zero.
module feedback_echo_with_peak_meter_core
    import fbecho_pkg::*;
#(
    parameter int BUF_DEPTH         = 65536,
    parameter int LEVEL_TABLE_DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] out_sample, [27:16] meter_level, zero fill
    output logic                   m_tuser,   // [0] meter_updated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    fbecho_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    fbecho_datapath #(
        .BUF_DEPTH         (BUF_DEPTH),
        .LEVEL_TABLE_DEPTH (LEVEL_TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
